// ===== rtl/core/ljpe_pkg.sv =====
// shared types, constants and helpers of the lossless jpeg pair encoder
// used by ljpe_lane, ljpe_huff and lossless_jpeg_pair_predict_encode
package ljpe_pkg;

  localparam int ROW_PAIRS  = 4096;
  localparam int COL_W      = $clog2(ROW_PAIRS);
  localparam int SAMPLE_W   = 16;
  localparam int CAT_W      = 5;
  localparam int NUM_CATS   = 17;
  localparam int HUFF_DEPTH = 2 * NUM_CATS;
  localparam int HUFF_AW    = $clog2(HUFF_DEPTH);
  localparam int ADDR_W     = 4;

  // commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  // prediction kinds chosen at transfer time
  localparam logic [1:0] PK_INIT  = 2'd0;
  localparam logic [1:0] PK_LEFT  = 2'd1;
  localparam logic [1:0] PK_ABOVE = 2'd2;
  localparam logic [1:0] PK_MODE  = 2'd3;

  // predictor selection values
  localparam logic [2:0] PRED_A     = 3'd1;
  localparam logic [2:0] PRED_B     = 3'd2;
  localparam logic [2:0] PRED_C     = 3'd3;
  localparam logic [2:0] PRED_ABC   = 3'd4;
  localparam logic [2:0] PRED_AHALF = 3'd5;
  localparam logic [2:0] PRED_BHALF = 3'd6;
  localparam logic [2:0] PRED_AVG   = 3'd7;

  // register indexes
  localparam logic [1:0] REG_PRED = 2'd0;
  localparam logic [1:0] REG_BITS = 2'd1;
  localparam logic [1:0] REG_SEP  = 2'd2;

  localparam logic [CAT_W-1:0] CAT_FULL = 5'd16;

  typedef struct packed {
    logic        command;
    logic        image_start;
    logic        row_start;
    logic [15:0] sample_zero;
    logic [15:0] sample_one;
    logic        table_pick;
    logic [4:0]  table_category;
    logic [4:0]  load_code_length;
    logic [15:0] load_code_bits;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  code_length_zero;
    logic [15:0] code_zero;
    logic [3:0]  extra_length_zero;
    logic [14:0] extra_zero;
    logic [4:0]  code_length_one;
    logic [15:0] code_one;
    logic [3:0]  extra_length_one;
    logic [14:0] extra_one;
  } out_item_t;

  typedef struct packed {
    logic [CAT_W-1:0] cat;
    logic [3:0]       extra_len;
    logic [14:0]      extra;
  } lane_res_t;

  typedef struct packed {
    logic        command;
    logic        table_pick;
    logic [4:0]  table_category;
    logic [4:0]  load_code_length;
    logic [15:0] load_code_bits;
    logic        tbl_one;
    lane_res_t   lane_zero;
    lane_res_t   lane_one;
  } s2_t;

  // bit length of a 16-bit magnitude
  function automatic logic [CAT_W-1:0] cat_of(input logic [SAMPLE_W-1:0] mag);
    logic [CAT_W-1:0] c;
    c = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (mag[i]) c = CAT_W'(i + 1);
    end
    return c;
  endfunction

  function automatic logic [HUFF_AW-1:0] huff_addr(input logic tbl,
                                                   input logic [CAT_W-1:0] cat);
    logic [HUFF_AW-1:0] a;
    a = HUFF_AW'(cat);
    if (tbl) a = a + HUFF_AW'(NUM_CATS);
    return a;
  endfunction

endpackage

// ===== rtl/core/ljpe_lane.sv =====
// one channel lane: predictor, modular difference, category, extra bits
// depends on ljpe_pkg
module ljpe_lane (
  input  logic [1:0]               kind_i,
  input  logic [2:0]               mode_i,
  input  logic [15:0]              init_pred_i,
  input  logic [15:0]              ra_i,
  input  logic [15:0]              rb_i,
  input  logic [15:0]              rc_i,
  input  logic [15:0]              sample_i,
  output ljpe_pkg::lane_res_t      res_o
);

  logic signed [17:0] ra_s, rb_s, rc_s, mode_pred;
  logic [15:0] pred, diff, mag, bits, mask, masked;
  logic [ljpe_pkg::CAT_W-1:0] cat;

  assign ra_s = {2'b00, ra_i};
  assign rb_s = {2'b00, rb_i};
  assign rc_s = {2'b00, rc_i};

  always_comb begin
    case (mode_i)
      ljpe_pkg::PRED_A:     mode_pred = ra_s;
      ljpe_pkg::PRED_B:     mode_pred = rb_s;
      ljpe_pkg::PRED_C:     mode_pred = rc_s;
      ljpe_pkg::PRED_ABC:   mode_pred = ra_s + rb_s - rc_s;
      ljpe_pkg::PRED_AHALF: mode_pred = ra_s + ((rb_s - rc_s) >>> 1);
      ljpe_pkg::PRED_BHALF: mode_pred = rb_s + ((ra_s - rc_s) >>> 1);
      ljpe_pkg::PRED_AVG:   mode_pred = (ra_s + rb_s) >>> 1;
      default:              mode_pred = '0;
    endcase
  end

  always_comb begin
    unique case (kind_i)
      ljpe_pkg::PK_INIT:  pred = init_pred_i;
      ljpe_pkg::PK_LEFT:  pred = ra_i;
      ljpe_pkg::PK_ABOVE: pred = rb_i;
      default:            pred = mode_pred[15:0];
    endcase
  end

  // difference wraps modulo 2^16
  assign diff   = sample_i - pred;
  assign mag    = diff[15] ? (~diff + 16'd1) : diff;
  assign bits   = diff[15] ? (diff - 16'd1) : diff;
  assign cat    = ljpe_pkg::cat_of(mag);
  assign mask   = (16'd1 << cat[3:0]) - 16'd1;
  assign masked = bits & mask;

  always_comb begin
    res_o.cat = cat;
    if (cat == ljpe_pkg::CAT_FULL) begin
      res_o.extra_len = '0;
      res_o.extra     = '0;
    end else begin
      res_o.extra_len = cat[3:0];
      res_o.extra     = masked[14:0];
    end
  end

endmodule

// ===== rtl/core/ljpe_huff.sv =====
// merging stage: two-read huffman table store and the output register
// depends on ljpe_pkg
module ljpe_huff (
  input  logic                 clk,
  input  logic                 go_i,
  input  ljpe_pkg::s2_t        s2_i,
  output ljpe_pkg::out_item_t  out_o
);

  logic [20:0] huff_mem_r [ljpe_pkg::HUFF_DEPTH];
  ljpe_pkg::out_item_t out_r;
  logic [ljpe_pkg::HUFF_AW-1:0] waddr, raddr0, raddr1;

  assign waddr  = ljpe_pkg::huff_addr(s2_i.table_pick, s2_i.table_category);
  assign raddr0 = ljpe_pkg::huff_addr(1'b0, s2_i.lane_zero.cat);
  assign raddr1 = ljpe_pkg::huff_addr(s2_i.tbl_one, s2_i.lane_one.cat);

  always_ff @(posedge clk) begin
    if (go_i) begin
      if (s2_i.command == ljpe_pkg::CMD_LOAD) begin
        if (s2_i.table_category <= ljpe_pkg::CAT_FULL) begin
          huff_mem_r[waddr] <= {s2_i.load_code_length, s2_i.load_code_bits};
        end
      end else begin
        {out_r.code_length_zero, out_r.code_zero} <= huff_mem_r[raddr0];
        {out_r.code_length_one, out_r.code_one}   <= huff_mem_r[raddr1];
        out_r.extra_length_zero <= s2_i.lane_zero.extra_len;
        out_r.extra_zero        <= s2_i.lane_zero.extra;
        out_r.extra_length_one  <= s2_i.lane_one.extra_len;
        out_r.extra_one         <= s2_i.lane_one.extra;
      end
    end
  end

  assign out_o = out_r;

endmodule

// ===== rtl/core/lossless_jpeg_pair_predict_encode.sv =====
// top level of the lossless jpeg pair encoder: line store, control, lanes
// depends on ljpe_pkg, ljpe_lane, ljpe_huff
//
//   channel  signals                          transfer when
//   in       in_valid in_ready in_data        in_valid && in_ready
//   out      out_valid out_ready out_data     out_valid && out_ready
//   cfg      psel penable pwrite paddr pwdata psel && penable && pwrite
//            prdata pready
//
// one item per clock unless the output stalls; an encode transfer shows its
// result on out_data through three register stages (line store
// read, lane stage, table lookup into out_data)
// the line store's single read-first port sets the pace: one pair a cycle
// reset is synchronous and needs no clearing pass; stores start undefined
// a stalled output holds each stage in turn, and in_ready drops only when
// the first stage is full and cannot move on
module lossless_jpeg_pair_predict_encode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ljpe_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ljpe_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ljpe_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // configuration registers
  logic [2:0] pred_mode_r;
  logic [4:0] sample_bits_r;
  logic       sep_tables_r;
  logic       cfg_wr;
  logic [4:0] prec;
  logic [15:0] init_pred;

  // stage control
  logic v1_r, v2_r, out_valid_r;
  logic go1, go2, out_free, s2_free;
  logic acc, acc_enc;

  // prediction context
  logic [ljpe_pkg::COL_W-1:0] column_r, col_nxt, col;
  logic first_row_r, first_row_nxt;
  logic [31:0] left_r, rc_r;
  logic [1:0]  kind;

  // line store, read-first so the old row value comes back
  logic [31:0] line_mem_r [ljpe_pkg::ROW_PAIRS];
  logic [31:0] line_rd_r;

  // stage one payload
  ljpe_pkg::in_item_t s1_item_r;
  logic [1:0]  s1_kind_r;
  logic [31:0] s1_ra_r;

  // stage two payload
  ljpe_pkg::s2_t s2_r;
  ljpe_pkg::lane_res_t res0, res1;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      ljpe_pkg::REG_PRED: prdata = {29'd0, pred_mode_r};
      ljpe_pkg::REG_BITS: prdata = {27'd0, sample_bits_r};
      ljpe_pkg::REG_SEP:  prdata = {31'd0, sep_tables_r};
      default:            prdata = '0;
    endcase
  end

  // precision clamps to 1..16 for the first pair's prediction
  always_comb begin
    if (sample_bits_r == 5'd0) begin
      prec = 5'd1;
    end else if (sample_bits_r > 5'd16) begin
      prec = 5'd16;
    end else begin
      prec = sample_bits_r;
    end
  end
  assign init_pred = 16'd1 << (prec[3:0] - 4'd1);

  // ---------------------------------------------------------- stage control
  assign out_free = !out_valid_r || out_ready;
  // loads leave stage two by writing the table, encodes need the output slot
  assign go2      = v2_r && ((s2_r.command == ljpe_pkg::CMD_LOAD) || out_free);
  assign s2_free  = !v2_r || go2;
  assign go1      = v1_r && s2_free;
  assign in_ready = !v1_r || go1;
  assign acc      = in_valid && in_ready;
  assign acc_enc  = acc && (in_data.command == ljpe_pkg::CMD_ENCODE);
  assign out_valid = out_valid_r;

  // row position and prediction kind for the transfer
  always_comb begin
    first_row_nxt = first_row_r;
    col           = column_r;
    if (in_data.image_start) begin
      first_row_nxt = 1'b1;
      col           = '0;
    end else if (in_data.row_start) begin
      first_row_nxt = 1'b0;
      col           = '0;
    end
    col_nxt = (col == ljpe_pkg::COL_W'(ljpe_pkg::ROW_PAIRS - 1)) ? '0
                                                                 : col + ljpe_pkg::COL_W'(1);
    if (in_data.image_start) begin
      kind = ljpe_pkg::PK_INIT;
    end else if (first_row_nxt) begin
      kind = ljpe_pkg::PK_LEFT;
    end else if (in_data.row_start) begin
      kind = ljpe_pkg::PK_ABOVE;
    end else begin
      kind = ljpe_pkg::PK_MODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_mode_r   <= 3'd7;
      sample_bits_r <= 5'd16;
      sep_tables_r  <= 1'b1;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      column_r      <= '0;
      first_row_r   <= 1'b1;
      left_r        <= '0;
      rc_r          <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          ljpe_pkg::REG_PRED: pred_mode_r   <= pwdata[2:0];
          ljpe_pkg::REG_BITS: sample_bits_r <= pwdata[4:0];
          ljpe_pkg::REG_SEP:  sep_tables_r  <= pwdata[0];
          default: ;
        endcase
      end
      if (in_ready) v1_r <= in_valid;
      if (s2_free) v2_r <= go1;
      if (out_free) out_valid_r <= go2 && (s2_r.command == ljpe_pkg::CMD_ENCODE);
      if (acc_enc) begin
        column_r    <= col_nxt;
        first_row_r <= first_row_nxt;
        left_r      <= {in_data.sample_one, in_data.sample_zero};
      end
      // above-left follows the row-above value of the last encoded pair
      if (go1 && (s1_item_r.command == ljpe_pkg::CMD_ENCODE)) rc_r <= line_rd_r;
    end
  end

  // line store port and stage one payload
  always_ff @(posedge clk) begin
    if (acc_enc) begin
      line_rd_r       <= line_mem_r[col];
      line_mem_r[col] <= {in_data.sample_one, in_data.sample_zero};
    end
    if (acc) begin
      s1_item_r <= in_data;
      s1_kind_r <= kind;
      s1_ra_r   <= left_r;
    end
  end

  // ------------------------------------------------------------------ lanes
  ljpe_lane u_lane_zero (
    .kind_i      (s1_kind_r),
    .mode_i      (pred_mode_r),
    .init_pred_i (init_pred),
    .ra_i        (s1_ra_r[15:0]),
    .rb_i        (line_rd_r[15:0]),
    .rc_i        (rc_r[15:0]),
    .sample_i    (s1_item_r.sample_zero),
    .res_o       (res0)
  );

  ljpe_lane u_lane_one (
    .kind_i      (s1_kind_r),
    .mode_i      (pred_mode_r),
    .init_pred_i (init_pred),
    .ra_i        (s1_ra_r[31:16]),
    .rb_i        (line_rd_r[31:16]),
    .rc_i        (rc_r[31:16]),
    .sample_i    (s1_item_r.sample_one),
    .res_o       (res1)
  );

  always_ff @(posedge clk) begin
    if (go1) begin
      s2_r.command          <= s1_item_r.command;
      s2_r.table_pick       <= s1_item_r.table_pick;
      s2_r.table_category   <= s1_item_r.table_category;
      s2_r.load_code_length <= s1_item_r.load_code_length;
      s2_r.load_code_bits   <= s1_item_r.load_code_bits;
      s2_r.tbl_one          <= sep_tables_r;
      s2_r.lane_zero        <= res0;
      s2_r.lane_one         <= res1;
    end
  end

  // ------------------------------------------------------------ merge stage
  ljpe_huff u_huff (
    .clk   (clk),
    .go_i  (go2),
    .s2_i  (s2_r),
    .out_o (out_data)
  );

  // -------------------------------------------------------------- checks
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r)
    else $error("in_ready low with an empty first stage");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    go1 |=> v2_r)
    else $error("stage one moved but stage two is empty");

  a_image_column: assert property (@(posedge clk) disable iff (!rst_n)
    acc_enc && in_data.image_start |=> (column_r == ljpe_pkg::COL_W'(1)) && first_row_r)
    else $error("image start did not restart the row");

  a_row_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    acc_enc && !in_data.image_start && in_data.row_start |=> !first_row_r)
    else $error("row start left the first row flag set");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    go2 && (s2_r.command == ljpe_pkg::CMD_LOAD) && !out_ready |=> $stable(out_valid_r))
    else $error("table load changed the output valid");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of lossless_jpeg_pair_predict_encode
// uses ljpe_pkg types and constants; carries its own predictor of codes
// and extra bits, drives stalls and idles on both channels and checks in order
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;   // cycles with no transfer before giving up
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off, fills the pipe
  localparam int SEGMENTS    = 18;
  localparam int SEG_ITEMS   = 110;
  localparam int DRAIN_TAIL  = 8;      // pipe is three deep, loads give no result
  // precision settings walked by the first segments: reset value, then a mix of
  // legal ones and the out-of-range ones (0, 17, 31) that clamp
  localparam int PRECISION_STEPS [8] = '{16, 2, 0, 1, 17, 31, 9, 12};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  ljpe_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ljpe_pkg::out_item_t           out_data;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ljpe_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  lossless_jpeg_pair_predict_encode uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the line store, neighbors and tables
  // ---------------------------------------------------------------------------
  logic [15:0] line_mem [ljpe_pkg::ROW_PAIRS][2];
  logic [15:0] left_mem [2] = '{16'd0, 16'd0};
  logic [15:0] above_left_mem [2] = '{16'd0, 16'd0};
  int          cur_col = 0;
  bit          cur_first_row = 1'b1;
  logic [4:0]  huff_len_mem [2][ljpe_pkg::NUM_CATS];
  logic [15:0] huff_code_mem [2][ljpe_pkg::NUM_CATS];

  // mirror of the configuration registers, reset values
  logic [2:0] mode_reg = ljpe_pkg::PRED_AVG;
  logic [4:0] precision_reg = 5'd16;
  logic       separate_reg = 1'b1;

  ljpe_pkg::out_item_t expected_codes [$];   // codes still owed by the block, oldest first
  ljpe_pkg::in_item_t  pending_cmds [$];     // commands waiting for the driver
  int                  fail_count = 0;

  // traffic shaping; the idle percentages change only while the block is idle
  int send_idle_pct = 7;
  int recv_idle_pct = 72;
  int stalls_asked = 0;
  int stalls_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // generator's view of the row position, so that a row past the first never
  // reads a line store column that no earlier pair has written
  int          plan_col = 0;
  int          plan_extent = 0;
  bit          plan_first_row = 1'b1;
  logic [15:0] walk [2] = '{16'h8000, 16'h8000};

  // code and extra bits of one channel for a given prediction
  function automatic void code_lane(input logic [15:0] smp, input int pred, input bit tbl,
                                    output logic [4:0] len, output logic [15:0] code,
                                    output logic [3:0] xlen, output logic [14:0] xbits);
    logic [15:0] d;
    logic [15:0] bits;
    logic [16:0] mag;
    int          cat;
    d    = smp - 16'(pred);                     // wraps modulo 65536
    mag  = (d < 16'h8000) ? {1'b0, d} : 17'h10000 - {1'b0, d};
    bits = (d < 16'h8000) ? d : d - 16'd1;     // negative diffs send diff - 1
    cat  = 0;
    while (cat < 16 && (mag >> cat) != 0) cat++;
    len  = huff_len_mem[tbl][cat];
    code = huff_code_mem[tbl][cat];
    if (cat == 16) begin
      // difference of 32768: code only, no extra bits
      xlen  = '0;
      xbits = '0;
    end else begin
      xlen  = 4'(cat);
      xbits = 15'(bits & 16'((17'd1 << cat) - 17'd1));
    end
  endfunction

  // advance the predictor by one accepted command, queue the codes it owes
  task automatic predict_codes(input ljpe_pkg::in_item_t it);
    logic [15:0]         smp [2];
    int                  pred [2];
    int                  ra, rb, rc, p, col;
    ljpe_pkg::out_item_t res;
    if (it.command == ljpe_pkg::CMD_LOAD) begin
      // out-of-range categories are dropped
      if (int'(it.table_category) < ljpe_pkg::NUM_CATS) begin
        huff_len_mem[it.table_pick][it.table_category]  = it.load_code_length;
        huff_code_mem[it.table_pick][it.table_category] = it.load_code_bits;
      end
      return;
    end
    smp[0] = it.sample_zero;
    smp[1] = it.sample_one;
    if (it.image_start) begin
      cur_first_row = 1'b1;
      cur_col = 0;
    end else if (it.row_start) begin
      cur_first_row = 1'b0;
      cur_col = 0;
    end
    col = cur_col;
    for (int ch = 0; ch < 2; ch++) begin
      ra = int'(left_mem[ch]);
      rb = int'(line_mem[col][ch]);
      rc = int'(above_left_mem[ch]);
      if (it.image_start) begin
        // precision clamps into 1..16
        p = int'(precision_reg);
        if (p < 1) p = 1;
        if (p > 16) p = 16;
        pred[ch] = 1 << (p - 1);
      end else if (cur_first_row) begin
        pred[ch] = ra;
      end else if (it.row_start) begin
        pred[ch] = rb;
      end else begin
        case (mode_reg)
          ljpe_pkg::PRED_A:     pred[ch] = ra;
          ljpe_pkg::PRED_B:     pred[ch] = rb;
          ljpe_pkg::PRED_C:     pred[ch] = rc;
          ljpe_pkg::PRED_ABC:   pred[ch] = ra + rb - rc;
          ljpe_pkg::PRED_AHALF: pred[ch] = ra + ((rb - rc) >>> 1);
          ljpe_pkg::PRED_BHALF: pred[ch] = rb + ((ra - rc) >>> 1);
          ljpe_pkg::PRED_AVG:   pred[ch] = (ra + rb) >>> 1;
          default:              pred[ch] = 0;             // mode zero predicts zero
        endcase
      end
    end
    code_lane(smp[0], pred[0], 1'b0, res.code_length_zero, res.code_zero,
              res.extra_length_zero, res.extra_zero);
    code_lane(smp[1], pred[1], separate_reg, res.code_length_one, res.code_one,
              res.extra_length_one, res.extra_one);
    for (int ch = 0; ch < 2; ch++) begin
      above_left_mem[ch] = line_mem[col][ch];
      line_mem[col][ch]  = smp[ch];
      left_mem[ch]       = smp[ch];
    end
    cur_col = (col + 1 >= ljpe_pkg::ROW_PAIRS) ? 0 : col + 1;
    expected_codes.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_codes(input ljpe_pkg::out_item_t got);
    ljpe_pkg::out_item_t want;
    if (expected_codes.size() == 0) begin
      $display("%0t: result with nothing outstanding, expected none got %p", $time, got);
      fail_count++;
    end else begin
      want = expected_codes.pop_front();
      check_field("code_length_zero",  16'(want.code_length_zero),
                  16'(got.code_length_zero));
      check_field("code_zero",         want.code_zero, got.code_zero);
      check_field("extra_length_zero", 16'(want.extra_length_zero),
                  16'(got.extra_length_zero));
      check_field("extra_zero",        16'(want.extra_zero), 16'(got.extra_zero));
      check_field("code_length_one",   16'(want.code_length_one),
                  16'(got.code_length_one));
      check_field("code_one",          want.code_one, got.code_one);
      check_field("extra_length_one",  16'(want.extra_length_one),
                  16'(got.extra_length_one));
      check_field("extra_one",         16'(want.extra_one), 16'(got.extra_one));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one command per transfer, random idle slots
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // slot frees at this edge; offer the next command or idle
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on input transfers, checks output transfers, and
  // paces out_ready (random stalls plus the long hold-off on request)
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (in_valid && in_ready) predict_codes(in_data);
      if (out_valid && out_ready) compare_codes(out_data);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (stalls_done != stalls_asked) begin
        out_ready   <= 1'b0;
        hold_left   <= HOLD_CYCLES;
        stalls_done <= stalls_done + 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lossless_jpeg_pair_predict_encode: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // table entry load; flags and samples are don't-care and get random bits
  task automatic queue_load(input bit pick, input logic [4:0] cat, input logic [4:0] len,
                            input logic [15:0] code);
    ljpe_pkg::in_item_t it;
    it.command          = ljpe_pkg::CMD_LOAD;
    it.image_start      = 1'($urandom_range(0, 1));
    it.row_start        = 1'($urandom_range(0, 1));
    it.sample_zero      = 16'($urandom_range(0, 65535));
    it.sample_one       = 16'($urandom_range(0, 65535));
    it.table_pick       = pick;
    it.table_category   = cat;
    it.load_code_length = len;
    it.load_code_bits   = code;
    pending_cmds.push_back(it);
  endtask

  // encode of one pair; flags are bumped where needed so that no row past
  // the first reaches a column that was never written
  task automatic queue_pair(input bit img, input bit row, input logic [15:0] s0,
                            input logic [15:0] s1);
    ljpe_pkg::in_item_t it;
    if (!img) begin
      if (row && plan_extent == 0) img = 1'b1;
      else if (!row && !plan_first_row && plan_col >= plan_extent) row = 1'b1;
    end
    if (img) begin
      plan_first_row = 1'b1;
      plan_col = 0;
    end else if (row) begin
      plan_first_row = 1'b0;
      plan_col = 0;
    end
    if (plan_col + 1 > plan_extent) plan_extent = plan_col + 1;
    plan_col = (plan_col + 1) % ljpe_pkg::ROW_PAIRS;
    it.command          = ljpe_pkg::CMD_ENCODE;
    it.image_start      = img;
    it.row_start        = row;
    it.sample_zero      = s0;
    it.sample_one       = s1;
    it.table_pick       = 1'($urandom_range(0, 1));
    it.table_category   = 5'($urandom_range(0, 31));
    it.load_code_length = 5'($urandom_range(0, 31));
    it.load_code_bits   = 16'($urandom_range(0, 65535));
    pending_cmds.push_back(it);
  endtask

  // smooth-ish sample stream: random steps of random bit length, rare jumps
  function automatic logic [15:0] step_walk(input int ch);
    logic [15:0] delta;
    int          k;
    k = $urandom_range(0, 16);
    delta = 16'($urandom) & 16'((32'd1 << k) - 1);
    if ($urandom_range(0, 1)) walk[ch] = walk[ch] - delta;
    else walk[ch] = walk[ch] + delta;
    if ($urandom_range(0, 19) == 0) walk[ch] = 16'($urandom);
    return walk[ch];
  endfunction

  // mostly whole images of random size, with stray loads and broken pairs
  task automatic queue_traffic(input int n_items);
    int made, rows, width, roll;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        queue_load(1'($urandom_range(0, 1)), 5'($urandom_range(0, ljpe_pkg::NUM_CATS - 1)),
                   5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
        made++;
        // now and then a load with a category past the table, dropped
        if ($urandom_range(0, 3) == 0)
          queue_load(1'($urandom_range(0, 1)), 5'($urandom_range(ljpe_pkg::NUM_CATS, 31)),
                     5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
      end else if (roll < 11) begin
        queue_pair($urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0,
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        made++;
      end else begin
        rows  = $urandom_range(1, 5);
        width = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 16);
        // keep the segment near its item budget
        if (rows * width > n_items - made) begin
          rows = 1;
          if (width > n_items - made) width = n_items - made;
        end
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < width; c++) begin
            queue_pair(r == 0 && c == 0, c == 0, step_walk(0), step_walk(1));
          end
        end
        made += rows * width;
      end
    end
  endtask

  // wait until every command went in and every code came out, then let the
  // pipe settle since trailing loads owe no result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_codes.size() != 0);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // setup cycle then access cycle; the register takes pwdata at the access edge
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ljpe_pkg::REG_PRED: mode_reg = value[2:0];
      ljpe_pkg::REG_BITS: precision_reg = value[4:0];
      ljpe_pkg::REG_SEP:  separate_reg = value[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill both tables before any encode so every lookup hits a loaded entry
    for (int t = 0; t < 2; t++) begin
      for (int c = 0; c < ljpe_pkg::NUM_CATS; c++) begin
        queue_load(1'(t), 5'(c), 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
      end
    end
    queue_load(1'b0, 5'(ljpe_pkg::NUM_CATS), 5'd16, 16'hFFFF);   // bad categories, dropped
    queue_load(1'b1, 5'd31, 5'd31, 16'h0000);

    // directed pairs under reset config (avg predictor, 16 bits, split tables)
    queue_pair(1'b0, 1'b0, 16'h1234, 16'hFFFF);   // no image start after reset
    queue_pair(1'b0, 1'b1, 16'hFFFF, 16'h0000);   // row start alone, from above
    queue_pair(1'b1, 1'b0, 16'h0000, 16'hFFFF);   // image start: lane zero category sixteen
    queue_pair(1'b0, 1'b0, 16'h8000, 16'h7FFF);   // both lanes 32768 off
    queue_pair(1'b0, 1'b0, 16'h8000, 16'h7FFF);   // category zero
    queue_pair(1'b0, 1'b0, 16'h8001, 16'h7FFE);   // +1 and -1
    queue_pair(1'b0, 1'b0, 16'h0000, 16'hFFFF);
    queue_pair(1'b0, 1'b1, 16'h0000, 16'hFFFF);   // second row
    queue_pair(1'b0, 1'b0, 16'hFFFF, 16'h0000);
    queue_pair(1'b0, 1'b0, 16'h0001, 16'hFFFE);
    queue_pair(1'b0, 1'b0, 16'h7FFF, 16'h8000);
    queue_pair(1'b0, 1'b0, 16'hAAAA, 16'h5555);
    queue_pair(1'b1, 1'b1, 16'h4000, 16'hC000);   // image and row start together
    queue_pair(1'b0, 1'b0, 16'h3FFF, 16'hC001);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      // idle profile: sender light / receiver heavy, then swapped, then none
      if (seg == SEGMENTS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 7;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg < 8) begin
        write_reg(ljpe_pkg::REG_PRED, seg);
        write_reg(ljpe_pkg::REG_BITS, PRECISION_STEPS[seg]);
        write_reg(ljpe_pkg::REG_SEP, seg % 2);
      end else begin
        write_reg(ljpe_pkg::REG_PRED, $urandom_range(0, 7));
        write_reg(ljpe_pkg::REG_BITS, $urandom_range(0, 31));
        write_reg(ljpe_pkg::REG_SEP, $urandom_range(0, 1));
      end
      @(negedge clk);
      queue_traffic(SEG_ITEMS);
      // long receiver hold while the sender keeps offering
      if (seg == 2 || seg == 15) stalls_asked++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("lossless_jpeg_pair_predict_encode: match");
    end else begin
      $display("lossless_jpeg_pair_predict_encode: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ljpe_pkg.sv
rtl/core/ljpe_lane.sv
rtl/core/ljpe_huff.sv
rtl/core/lossless_jpeg_pair_predict_encode.sv
tb/tb_top.sv
